@@ src/touch_pad_zone_classifier_defines.svh @@
// ----------------------------------------------------------------------------
// touch pad zone classifier assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef TOUCH_PAD_ZONE_CLASSIFIER_DEFINES_SVH
`define TOUCH_PAD_ZONE_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TPZC_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPZC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TPZC_ASSERT_IMPL(label, ck, rn, ante, cons, msg)

`define TPZC_ASSERT_NEXT(label, ck, rn, ante, cons, msg)

`endif

`endif

@@ src/tpzc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpzc_pkg
// widths, pad geometry table and shared types of the touch pad classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpzc_pkg;

    localparam int PAD_COUNT  = 14;
    localparam int TABLE_PADS = 14;
    localparam int CELL_COUNT = ((PAD_COUNT < TABLE_PADS) ? PAD_COUNT : TABLE_PADS) - 1;

    localparam int COORD_W = 10;
    localparam int IDX_W   = 4;
    localparam int NOTE_W  = 7;
    localparam int CFG_W   = 1;
    localparam int OFF_W   = 9;
    localparam int D_W     = 12;
    localparam int CD_W    = 11;
    localparam int SQ_W    = 21;
    localparam int R2_W    = 12;
    localparam int NUM_W   = 34;
    localparam int DEN_W   = 24;
    localparam int PROD_W  = 2 * DEN_W;

    localparam logic [COORD_W-1:0] CENTER_RESET = COORD_W'(233);
    localparam logic [SQ_W-1:0]    CENTER_R2    = SQ_W'(72 * 72);

    // register indexes
    localparam logic [CFG_W-1:0] CFG_CENTER_X = 1'b0;
    localparam logic [CFG_W-1:0] CFG_CENTER_Y = 1'b1;

    // one touch travelling down the chain with its running best match
    typedef struct packed {
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic               center;
        logic               best_valid;
        logic [IDX_W-1:0]   best_idx;
        logic [DEN_W-1:0]   best_num;
        logic [DEN_W-1:0]   best_den;
    } tpzc_item_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  pad_index;
        logic [NOTE_W-1:0] midi_note;
    } tpzc_result_t;

    function automatic logic signed [OFF_W-1:0] pad_off_x(input logic [IDX_W-1:0] idx);
        logic signed [OFF_W-1:0] v;
        case (idx)
            4'd1:    v = -9'sd86;
            4'd2:    v = -9'sd54;
            4'd3:    v = 9'sd19;
            4'd4:    v = 9'sd77;
            4'd5:    v = 9'sd77;
            4'd6:    v = 9'sd19;
            4'd7:    v = -9'sd54;
            4'd8:    v = -9'sd133;
            4'd9:    v = -9'sd10;
            4'd10:   v = 9'sd122;
            4'd11:   v = 9'sd133;
            4'd12:   v = 9'sd10;
            4'd13:   v = -9'sd122;
            default: v = 9'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [OFF_W-1:0] pad_off_y(input logic [IDX_W-1:0] idx);
        logic signed [OFF_W-1:0] v;
        case (idx)
            4'd1:    v = 9'sd0;
            4'd2:    v = -9'sd66;
            4'd3:    v = -9'sd83;
            4'd4:    v = -9'sd37;
            4'd5:    v = 9'sd37;
            4'd6:    v = 9'sd83;
            4'd7:    v = 9'sd66;
            4'd8:    v = -9'sd64;
            4'd9:    v = -9'sd147;
            4'd10:   v = -9'sd82;
            4'd11:   v = 9'sd64;
            4'd12:   v = 9'sd147;
            4'd13:   v = 9'sd82;
            default: v = 9'sd0;
        endcase
        return v;
    endfunction

    // squared semi-axes: inner ring 48 x 62, outer ring 45 x 56
    function automatic logic [R2_W-1:0] pad_rx2(input logic [IDX_W-1:0] idx);
        logic [R2_W-1:0] v;
        case (idx) inside
            [4'd1:4'd7]:  v = R2_W'(48 * 48);
            [4'd8:4'd13]: v = R2_W'(45 * 45);
            default:      v = R2_W'(68 * 68);
        endcase
        return v;
    endfunction

    function automatic logic [R2_W-1:0] pad_ry2(input logic [IDX_W-1:0] idx);
        logic [R2_W-1:0] v;
        case (idx) inside
            [4'd1:4'd7]:  v = R2_W'(62 * 62);
            [4'd8:4'd13]: v = R2_W'(56 * 56);
            default:      v = R2_W'(68 * 68);
        endcase
        return v;
    endfunction

    function automatic logic [NOTE_W-1:0] pad_note(input logic [IDX_W-1:0] idx);
        logic [NOTE_W-1:0] v;
        case (idx)
            4'd0:    v = 7'd50;
            4'd1:    v = 7'd57;
            4'd2:    v = 7'd58;
            4'd3:    v = 7'd60;
            4'd4:    v = 7'd62;
            4'd5:    v = 7'd64;
            4'd6:    v = 7'd65;
            4'd7:    v = 7'd67;
            4'd8:    v = 7'd69;
            4'd9:    v = 7'd72;
            4'd10:   v = 7'd74;
            4'd11:   v = 7'd76;
            4'd12:   v = 7'd77;
            4'd13:   v = 7'd81;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/tpzc_if.sv @@
// ----------------------------------------------------------------------------
// tpzc channel interfaces
// valid/ready channels for touch words, result words and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tpzc_touch_if;
    import tpzc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] touch_x;
    logic [COORD_W-1:0] touch_y;

    modport source (output valid, output touch_x, output touch_y, input ready);
    modport sink   (input valid, input touch_x, input touch_y, output ready);
endinterface

interface tpzc_result_if;
    import tpzc_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [IDX_W-1:0]  pad_index;
    logic [NOTE_W-1:0] midi_note;

    modport source (output valid, output hit, output pad_index, output midi_note,
                    input ready);
    modport sink   (input valid, input hit, input pad_index, input midi_note,
                    output ready);
endinterface

interface tpzc_cfg_if;
    import tpzc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CFG_W-1:0]   index;
    logic [COORD_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/touch_pad_zone_classifier.sv @@
// ----------------------------------------------------------------------------
// touch_pad_zone_classifier
// maps a touch point to one pad of a round fourteen-pad layout
// ----------------------------------------------------------------------------
// The block takes one touch word per cycle while the skid stage is empty and
// returns one result word per touch, in order. A point within radius 72 of the
// layout center (boundary included) selects pad 0; otherwise each ring pad is
// tested as an ellipse and the best fit wins, the lower pad on a tie. A miss
// gives hit 0, pad 0, note 0. Throughput is one word per cycle while the skid
// stage is empty. A touch passes the center disc test registers, one cell per
// ring pad in the chain and the output register. Each pad cell is pipelined
// through the multiplier stages it needs: offset square, axis scaling, cross
// product, compare. The center registers are written through the cfg
// channel, which is always ready; each touch takes the center values that
// hold when it is accepted, and writes are meant for times when no touch is
// in flight. Stalls on the result side back up the whole chain through a skid
// stage, so the touch side keeps accepting while one finished word waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_pad_zone_classifier (
    input  logic          clk,
    input  logic          rst_n,
    tpzc_cfg_if.sink      cfg,
    tpzc_touch_if.sink    touch,
    tpzc_result_if.source result
);
    import tpzc_pkg::*;

    // layout center registers
    logic [COORD_W-1:0] center_x_reg;
    logic [COORD_W-1:0] center_y_reg;

    // chain enable, low while the skid stage holds a word
    logic en;

    // cell chain links, entry 0 comes from the center test
    logic       chain_valid [0:CELL_COUNT];
    tpzc_item_t chain_item  [0:CELL_COUNT];

    tpzc_result_t out_word;

    assign cfg.ready = 1'b1;

    // register writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_RESET;
            center_y_reg <= CENTER_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CENTER_X: center_x_reg <= cfg.data;
                CFG_CENTER_Y: center_y_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // touch word enters whenever the chain moves
    assign touch.ready = en;

    tpzc_head u_head (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (touch.valid),
        .tx      (touch.touch_x),
        .ty      (touch.touch_y),
        .cx      (center_x_reg),
        .cy      (center_y_reg),
        .valid_o (chain_valid[0]),
        .item_o  (chain_item[0])
    );

    // one cell per ring pad, in ascending pad order
    for (genvar g = 0; g < CELL_COUNT; g++)
    begin : g_cell
        tpzc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .pad_id  (IDX_W'(g + 1)),
            .valid_i (chain_valid[g]),
            .item_i  (chain_item[g]),
            .valid_o (chain_valid[g + 1]),
            .item_o  (chain_item[g + 1])
        );
    end

    tpzc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_i   (chain_valid[CELL_COUNT]),
        .item_i    (chain_item[CELL_COUNT]),
        .en        (en),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_word  (out_word)
    );

    assign result.hit       = out_word.hit;
    assign result.pad_index = out_word.pad_index;
    assign result.midi_note = out_word.midi_note;

endmodule

@@ src/tpzc_head.sv @@
// ----------------------------------------------------------------------------
// tpzc_head
// center disc test ahead of the pad cell chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpzc_head (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_i,
    input  logic [tpzc_pkg::COORD_W-1:0] tx,
    input  logic [tpzc_pkg::COORD_W-1:0] ty,
    input  logic [tpzc_pkg::COORD_W-1:0] cx,
    input  logic [tpzc_pkg::COORD_W-1:0] cy,
    output logic                         valid_o,
    output tpzc_pkg::tpzc_item_t         item_o
);
    import tpzc_pkg::*;

    logic signed [CD_W-1:0]   cdx;
    logic signed [CD_W-1:0]   cdy;
    logic signed [2*CD_W-1:0] cdx_sq;
    logic signed [2*CD_W-1:0] cdy_sq;

    logic               h1_valid_reg;
    logic [COORD_W-1:0] h1_tx_reg;
    logic [COORD_W-1:0] h1_ty_reg;
    logic [COORD_W-1:0] h1_cx_reg;
    logic [COORD_W-1:0] h1_cy_reg;
    logic [SQ_W-1:0]    h1_cdx2_reg;
    logic [SQ_W-1:0]    h1_cdy2_reg;

    logic               valid_reg;
    tpzc_item_t         item_reg;
    tpzc_item_t         item_next;
    logic [SQ_W-1:0]    dist2;

    // offset from the layout center, squared
    always_comb
    begin
        cdx    = signed'({1'b0, tx}) - signed'({1'b0, cx});
        cdy    = signed'({1'b0, ty}) - signed'({1'b0, cy});
        cdx_sq = cdx * cdx;
        cdy_sq = cdy * cdy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else if (en)
        begin
            h1_valid_reg <= valid_i;
            valid_reg    <= h1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_tx_reg   <= tx;
            h1_ty_reg   <= ty;
            h1_cx_reg   <= cx;
            h1_cy_reg   <= cy;
            h1_cdx2_reg <= cdx_sq[SQ_W-1:0];
            h1_cdy2_reg <= cdy_sq[SQ_W-1:0];
            item_reg    <= item_next;
        end
    end

    // boundary counts as inside the disc
    always_comb
    begin
        dist2               = h1_cdx2_reg + h1_cdy2_reg;
        item_next.tx        = h1_tx_reg;
        item_next.ty        = h1_ty_reg;
        item_next.cx        = h1_cx_reg;
        item_next.cy        = h1_cy_reg;
        item_next.center    = (dist2 <= CENTER_R2);
        item_next.best_valid = item_next.center;
        item_next.best_idx  = '0;
        item_next.best_num  = '0;
        item_next.best_den  = '0;
    end

    assign valid_o = valid_reg;
    assign item_o  = item_reg;

endmodule

@@ src/tpzc_cell.sv @@
// ----------------------------------------------------------------------------
// tpzc_cell
// one ellipse pad: distance, fit test and running best update, four stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpzc_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [tpzc_pkg::IDX_W-1:0] pad_id,
    input  logic                       valid_i,
    input  tpzc_pkg::tpzc_item_t       item_i,
    output logic                       valid_o,
    output tpzc_pkg::tpzc_item_t       item_o
);
    import tpzc_pkg::*;

    logic [R2_W-1:0]  rx2;
    logic [R2_W-1:0]  ry2;
    logic [DEN_W-1:0] den;

    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    logic signed [2*D_W-1:0] dx_sq;
    logic signed [2*D_W-1:0] dy_sq;

    // stage 1: squared offsets
    logic            s1_valid_reg;
    tpzc_item_t      s1_item_reg;
    logic [SQ_W-1:0] s1_dx2_reg;
    logic [SQ_W-1:0] s1_dy2_reg;

    // stage 2: scaled distance numerator
    logic             s2_valid_reg;
    tpzc_item_t       s2_item_reg;
    logic [NUM_W-1:0] s2_num_reg;
    logic [NUM_W-1:0] s2_num_next;

    // stage 3: fit flag and cross products
    logic              s3_valid_reg;
    tpzc_item_t        s3_item_reg;
    logic              s3_cand_reg;
    logic              s3_cand_next;
    logic [DEN_W-1:0]  s3_num_reg;
    logic [PROD_W-1:0] s3_pnew_reg;
    logic [PROD_W-1:0] s3_pnew_next;
    logic [PROD_W-1:0] s3_pbest_reg;
    logic [PROD_W-1:0] s3_pbest_next;

    // stage 4: cell output
    logic       out_valid_reg;
    tpzc_item_t out_item_reg;
    tpzc_item_t out_item_next;

    always_comb
    begin
        rx2 = pad_rx2(pad_id);
        ry2 = pad_ry2(pad_id);
        den = DEN_W'(rx2) * DEN_W'(ry2);
    end

    always_comb
    begin
        dx = D_W'(signed'({1'b0, item_i.tx})) - D_W'(signed'({1'b0, item_i.cx}))
             - D_W'(pad_off_x(pad_id));
        dy = D_W'(signed'({1'b0, item_i.ty})) - D_W'(signed'({1'b0, item_i.cy}))
             - D_W'(pad_off_y(pad_id));
        dx_sq = dx * dx;
        dy_sq = dy * dy;
    end

    always_comb
    begin
        s2_num_next = NUM_W'(s1_dx2_reg) * NUM_W'(ry2) + NUM_W'(s1_dy2_reg) * NUM_W'(rx2);
    end

    // cross products only matter once the point fits, so the numerator is at or below den
    always_comb
    begin
        s3_cand_next  = !s2_item_reg.center && (s2_num_reg <= NUM_W'(den));
        s3_pnew_next  = PROD_W'(s2_num_reg[DEN_W-1:0]) * PROD_W'(s2_item_reg.best_den);
        s3_pbest_next = PROD_W'(s2_item_reg.best_num) * PROD_W'(den);
    end

    // strictly smaller wins, so an earlier pad keeps a tie
    always_comb
    begin
        out_item_next = s3_item_reg;
        if (s3_cand_reg && (!s3_item_reg.best_valid || (s3_pnew_reg < s3_pbest_reg)))
        begin
            out_item_next.best_valid = 1'b1;
            out_item_next.best_idx   = pad_id;
            out_item_next.best_num   = s3_num_reg;
            out_item_next.best_den   = den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= valid_i;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg  <= item_i;
            s1_dx2_reg   <= dx_sq[SQ_W-1:0];
            s1_dy2_reg   <= dy_sq[SQ_W-1:0];
            s2_item_reg  <= s1_item_reg;
            s2_num_reg   <= s2_num_next;
            s3_item_reg  <= s2_item_reg;
            s3_cand_reg  <= s3_cand_next;
            s3_num_reg   <= s2_num_reg[DEN_W-1:0];
            s3_pnew_reg  <= s3_pnew_next;
            s3_pbest_reg <= s3_pbest_next;
            out_item_reg <= out_item_next;
        end
    end

    assign valid_o = out_valid_reg;
    assign item_o  = out_item_reg;

endmodule

@@ src/tpzc_out.sv @@
// ----------------------------------------------------------------------------
// tpzc_out
// result formatting, output register and skid stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "touch_pad_zone_classifier_defines.svh"

module tpzc_out (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_i,
    input  tpzc_pkg::tpzc_item_t    item_i,
    output logic                    en,
    output logic                    out_valid,
    input  logic                    out_ready,
    output tpzc_pkg::tpzc_result_t  out_word
);
    import tpzc_pkg::*;

    tpzc_result_t new_word;

    logic         out_valid_reg;
    logic         out_valid_next;
    tpzc_result_t out_word_reg;
    tpzc_result_t out_word_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    tpzc_result_t skid_word_reg;
    tpzc_result_t skid_word_next;
    logic         push;

    // no hit reads as pad 0, note 0
    always_comb
    begin
        new_word.hit       = item_i.best_valid;
        new_word.pad_index = item_i.best_valid ? item_i.best_idx : '0;
        new_word.midi_note = item_i.best_valid ? pad_note(item_i.best_idx) : '0;
    end

    assign en   = !skid_valid_reg;
    assign push = en && valid_i;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_valid_next = 1'b1;
                out_word_next  = new_word;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `TPZC_ASSERT_IMPL(a_skid_implies_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid word without output word")
    `TPZC_ASSERT_IMPL(a_skid_fill_on_stall, clk, rst_n, $rose(skid_valid_reg),
        $past(out_valid_reg) && !$past(out_ready), "skid filled while output was free")
    `TPZC_ASSERT_IMPL(a_miss_is_zero, clk, rst_n, out_valid_reg && !out_word_reg.hit,
        out_word_reg.pad_index == '0 && out_word_reg.midi_note == '0,
        "miss word carries pad or note")
    `TPZC_ASSERT_NEXT(a_skid_drains_first, clk, rst_n, skid_valid_reg && out_ready,
        out_valid_reg && en && out_word_reg == $past(skid_word_reg),
        "skid word not moved to output")

endmodule
